// ----- rtl/core/mi4_pkg.sv -----
// Shared types and index helpers for the 4x4 matrix inverse block.
// No dependencies; used by the controller and the datapath.
package mi4_pkg;

    typedef enum logic [1:0] {X_HOLD, X_ELEM, X_PROD, X_ACC} x_op_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {OUT_NONE, OUT_QUOT, OUT_ELEM} out_op_t;

    typedef struct packed {
        logic       load_en;
        logic [3:0] wr_addr;
        logic       rd_en;
        logic [3:0] rd_addr;
        x_op_t      x_op;
        logic       mul_start;
        acc_op_t    acc_op;
        logic       det_clr;
        logic       det_add;
        logic       det_abs;
        logic       cof_wr;
        logic       cof_rd;
        logic [3:0] cof_addr;
        logic       div_start;
        out_op_t    out_op;
        logic [3:0] out_index;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic det_zero;
        logic out_free;
    } dp_status_t;

    // Column picked by permutation p for minor row i.
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] i);
        logic [5:0] cols;
        begin
            case (p)
                3'd0:    cols = {2'd2, 2'd1, 2'd0};
                3'd1:    cols = {2'd0, 2'd2, 2'd1};
                3'd2:    cols = {2'd1, 2'd0, 2'd2};
                3'd3:    cols = {2'd1, 2'd2, 2'd0};
                3'd4:    cols = {2'd0, 2'd1, 2'd2};
                3'd5:    cols = {2'd2, 2'd0, 2'd1};
                default: cols = 6'd0;
            endcase
            case (i)
                2'd0:    perm_col = cols[1:0];
                2'd1:    perm_col = cols[3:2];
                default: perm_col = cols[5:4];
            endcase
        end
    endfunction

    // Storage address of factor i of term p of the adjugate entry k.
    // Minor rows skip column index of k, minor columns skip its row index.
    function automatic logic [3:0] minor_addr(input logic [3:0] k, input logic [2:0] p,
                                              input logic [1:0] i);
        logic [1:0] j;
        logic [1:0] row;
        logic [1:0] col;
        begin
            j   = perm_col(p, i);
            row = i + {1'b0, (i >= k[3:2])};
            col = j + {1'b0, (j >= k[1:0])};
            minor_addr = {col, row};
        end
    endfunction

    // Odd permutations and odd (row + column) both flip the sign.
    function automatic logic term_negative(input logic [3:0] k, input logic [2:0] p);
        term_negative = (p >= 3'd3) ^ k[0] ^ k[2];
    endfunction

endpackage

// ----- rtl/core/mi4_mul.sv -----
// Bit-serial signed multiplier: wide multiplicand times a narrow signed factor.
// Standalone; used by mi4_datapath.
module mi4_mul #(
    parameter int MW = 32,
    parameter int PW = 131
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [PW-1:0] x_in,
    input  logic [MW-1:0] m_in,
    output logic          busy,
    output logic [PW-1:0] prod
);
    localparam int CNTW = $clog2(MW + 1);

    logic [PW-1:0]   x_reg;
    logic [MW-1:0]   m_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   acc_next;
    logic [CNTW-1:0] cnt_reg;
    logic            last_bit;

    assign last_bit = (cnt_reg == CNTW'(1));

    // The top bit of the factor carries negative weight.
    always_comb begin
        if (!m_reg[0]) begin
            acc_next = acc_reg;
        end else if (last_bit) begin
            acc_next = acc_reg - x_reg;
        end else begin
            acc_next = acc_reg + x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            x_reg   <= x_in;
            m_reg   <= m_in;
            acc_reg <= '0;
            cnt_reg <= CNTW'(MW);
        end else if (cnt_reg != '0) begin
            acc_reg <= acc_next;
            x_reg   <= x_reg << 1;
            m_reg   <= m_reg >> 1;
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

// ----- rtl/core/mi4_div.sv -----
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
// Standalone; used by mi4_datapath.
module mi4_div #(
    parameter int NW = 128,
    parameter int DW = 130
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    output logic          busy,
    output logic [NW-1:0] quot
);
    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   num_reg;
    logic [DW-1:0]   den_reg;
    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   quot_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW:0]     rem_sh;
    logic [DW:0]     rem_sub;
    logic            ge;

    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign ge      = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            num_reg  <= num_in;
            den_reg  <= den_in;
            rem_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= CNTW'(NW);
        end else if (cnt_reg != '0) begin
            rem_reg  <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            quot_reg <= {quot_reg[NW-2:0], ge};
            num_reg  <= num_reg << 1;
            cnt_reg  <= cnt_reg - CNTW'(1);
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

// ----- rtl/core/mi4_datapath.sv -----
// Datapath: element store, cofactor store, accumulators, multiplier, divider,
// output register. Depends on mi4_pkg, mi4_mul and mi4_div.
module mi4_datapath #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mi4_pkg::dp_cmd_t       cmd,
    output mi4_pkg::dp_status_t    status,
    input  logic [VALUE_WIDTH-1:0] s_element_value,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [VALUE_WIDTH-1:0] m_result_value,
    output logic [3:0]             m_result_index,
    output logic                   m_singular,
    output logic                   m_saturated,
    output logic                   m_last
);
    import mi4_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 4 * W + 3;
    localparam int CW = 3 * W + 1;
    localparam int DW = 4 * W + 2;
    localparam int NW = 3 * W + 2 * FRACTION_BITS;

    logic [W-1:0]  elem_mem [16];
    logic [W-1:0]  rd_data_reg;
    logic [CW-1:0] cof_mem [16];
    logic [CW-1:0] cof_rd_reg;

    logic [PW-1:0] x_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] det_reg;
    logic [DW-1:0] dmag_reg;
    logic          dneg_reg;
    logic          nneg_reg;

    logic [PW-1:0] prod;
    logic          mul_busy;
    logic [NW-1:0] quot;
    logic          div_busy;

    logic [PW-1:0]   det_abs;
    logic [CW-1:0]   cof_abs;
    logic [NW-1:0]   num;
    logic            qneg;
    logic [W-1:0]    lim_w;
    logic            sat;
    logic [W-1:0]    mag_w;
    logic [W-1:0]    quot_val;

    logic            m_valid_reg;
    logic [W-1:0]    value_reg;
    logic [3:0]      index_reg;
    logic            singular_reg;
    logic            saturated_reg;
    logic            last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            elem_mem[cmd.wr_addr] <= s_element_value;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= elem_mem[cmd.rd_addr];
        end
        if (cmd.cof_wr) begin
            cof_mem[cmd.cof_addr] <= acc_reg[CW-1:0];
        end
        if (cmd.cof_rd) begin
            cof_rd_reg <= cof_mem[cmd.cof_addr];
        end
    end

    mi4_mul #(.MW(W), .PW(PW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x_in    (x_reg),
        .m_in    (rd_data_reg),
        .busy    (mul_busy),
        .prod    (prod)
    );

    assign det_abs = det_reg[PW-1] ? (PW'(0) - det_reg) : det_reg;
    assign cof_abs = cof_rd_reg[CW-1] ? (CW'(0) - cof_rd_reg) : cof_rd_reg;
    assign num     = {cof_abs[CW-2:0], {(2 * FRACTION_BITS){1'b0}}};

    mi4_div #(.NW(NW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num_in  (num),
        .den_in  (dmag_reg),
        .busy    (div_busy),
        .quot    (quot)
    );

    always_ff @(posedge aclk) begin
        case (cmd.x_op)
            X_ELEM:  x_reg <= {{(PW - W){rd_data_reg[W-1]}}, rd_data_reg};
            X_PROD:  x_reg <= prod;
            X_ACC:   x_reg <= acc_reg;
            default: x_reg <= x_reg;
        endcase
        case (cmd.acc_op)
            ACC_CLR: acc_reg <= '0;
            ACC_ADD: acc_reg <= acc_reg + prod;
            ACC_SUB: acc_reg <= acc_reg - prod;
            default: acc_reg <= acc_reg;
        endcase
        if (cmd.det_clr) begin
            det_reg <= '0;
        end else if (cmd.det_add) begin
            det_reg <= det_reg + prod;
        end
        if (cmd.det_abs) begin
            dmag_reg <= det_abs[DW-1:0];
            dneg_reg <= det_reg[PW-1];
        end
        if (cmd.div_start) begin
            nneg_reg <= cof_rd_reg[CW-1];
        end
    end

    // Clamp the quotient magnitude, then apply the sign.
    assign qneg     = nneg_reg ^ dneg_reg;
    assign lim_w    = qneg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    assign sat      = (quot > {{(NW - W){1'b0}}, lim_w});
    assign mag_w    = sat ? lim_w : quot[W-1:0];
    assign quot_val = qneg ? (W'(0) - mag_w) : mag_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_op != OUT_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.out_op)
            OUT_QUOT: begin
                value_reg     <= quot_val;
                singular_reg  <= 1'b0;
                saturated_reg <= sat;
            end
            OUT_ELEM: begin
                value_reg     <= rd_data_reg;
                singular_reg  <= 1'b1;
                saturated_reg <= 1'b0;
            end
            default: begin
                value_reg     <= value_reg;
                singular_reg  <= singular_reg;
                saturated_reg <= saturated_reg;
            end
        endcase
        if (cmd.out_op != OUT_NONE) begin
            index_reg <= cmd.out_index;
            last_reg  <= (cmd.out_index == 4'd15);
        end
    end

    assign status.mul_busy = mul_busy;
    assign status.div_busy = div_busy;
    assign status.det_zero = (det_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_result_value = value_reg;
    assign m_result_index = index_reg;
    assign m_singular     = singular_reg;
    assign m_saturated    = saturated_reg;
    assign m_last         = last_reg;

endmodule

// ----- rtl/core/mi4_ctrl.sv -----
// Sequencer for loading, cofactor/determinant accumulation, division and emit.
// Depends on mi4_pkg; drives mi4_datapath through dp_cmd_t.
module mi4_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output mi4_pkg::dp_cmd_t    cmd,
    input  mi4_pkg::dp_status_t status
);
    import mi4_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_COF_INIT, S_RD0, S_RD1, S_MUL1, S_WAIT1, S_MUL2, S_WAIT2,
        S_COF_DONE, S_DMUL, S_DWAIT, S_CHECK, S_QRD, S_QSTART, S_QOUT, S_SOUT
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] k_reg, k_next;
    logic [2:0] p_reg, p_next;
    logic [3:0] load_cnt_reg, load_cnt_next;
    logic       k_last;

    assign k_last = (k_reg == 4'd15);

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        p_next        = p_reg;
        load_cnt_next = load_cnt_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.wr_addr   = load_cnt_reg;
        cmd.cof_addr  = k_reg;
        cmd.out_index = k_reg;
        unique case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_en   = 1'b1;
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15) begin
                        cmd.det_clr = 1'b1;
                        k_next      = '0;
                        state_next  = S_COF_INIT;
                    end
                end
            end
            S_COF_INIT: begin
                cmd.acc_op = ACC_CLR;
                p_next     = '0;
                state_next = S_RD0;
            end
            S_RD0: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = minor_addr(k_reg, p_reg, 2'd0);
                state_next  = S_RD1;
            end
            S_RD1: begin
                cmd.x_op    = X_ELEM;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = minor_addr(k_reg, p_reg, 2'd1);
                state_next  = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_start = 1'b1;
                state_next    = S_WAIT1;
            end
            S_WAIT1: begin
                if (!status.mul_busy) begin
                    cmd.x_op    = X_PROD;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = minor_addr(k_reg, p_reg, 2'd2);
                    state_next  = S_MUL2;
                end
            end
            S_MUL2: begin
                cmd.mul_start = 1'b1;
                state_next    = S_WAIT2;
            end
            S_WAIT2: begin
                if (!status.mul_busy) begin
                    cmd.acc_op = term_negative(k_reg, p_reg) ? ACC_SUB : ACC_ADD;
                    if (p_reg == 3'd5) begin
                        state_next = S_COF_DONE;
                    end else begin
                        p_next     = p_reg + 3'd1;
                        state_next = S_RD0;
                    end
                end
            end
            S_COF_DONE: begin
                cmd.cof_wr = 1'b1;
                if (k_reg[1:0] == 2'd0) begin
                    cmd.x_op    = X_ACC;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = {2'b00, k_reg[3:2]};
                    state_next  = S_DMUL;
                end else if (k_last) begin
                    state_next = S_CHECK;
                end else begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_COF_INIT;
                end
            end
            S_DMUL: begin
                cmd.mul_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT: begin
                if (!status.mul_busy) begin
                    cmd.det_add = 1'b1;
                    k_next      = k_reg + 4'd1;
                    state_next  = S_COF_INIT;
                end
            end
            S_CHECK: begin
                cmd.det_abs = 1'b1;
                k_next      = '0;
                state_next  = status.det_zero ? S_SOUT : S_QRD;
                if (status.det_zero) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = 4'd0;
                end
            end
            S_QRD: begin
                cmd.cof_rd = 1'b1;
                state_next = S_QSTART;
            end
            S_QSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_QOUT;
            end
            S_QOUT: begin
                if (!status.div_busy && status.out_free) begin
                    cmd.out_op = OUT_QUOT;
                    k_next     = k_reg + 4'd1;
                    state_next = k_last ? S_LOAD : S_QRD;
                end
            end
            S_SOUT: begin
                // Read data for this index was fetched earlier and is held.
                if (status.out_free) begin
                    cmd.out_op  = OUT_ELEM;
                    k_next      = k_reg + 4'd1;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = k_reg + 4'd1;
                    state_next  = k_last ? S_LOAD : S_SOUT;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            k_reg        <= '0;
            p_reg        <= '0;
            load_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            p_reg        <= p_next;
            load_cnt_reg <= load_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD) |-> (!status.mul_busy && !status.div_busy))
        else $error("loading while a unit is busy");

    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !status.mul_busy)
        else $error("multiply started while busy");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divide started while busy");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_op != OUT_NONE) |-> status.out_free)
        else $error("result overwritten before it was taken");
`endif

endmodule

// ----- rtl/core/matrix_inverse_4x4.sv -----
// Top level of the 4x4 fixed-point matrix inverse (adjugate method).
// Depends on mi4_pkg, mi4_ctrl and mi4_datapath.
//
// Input channel (s_): one signed Q element per item, column-major order.
// Output channel (m_): 16 items per matrix, column-major, each with its
// index, a singular flag, a saturated flag and last on index 15.
// Items 1..16 of a matrix are taken one per cycle. After the 16th item the
// block stops taking input while it works: each adjugate entry is six
// triple products built on a bit-serial multiplier, the determinant adds
// four more multiplies, and each inverse element goes through a restoring
// divider with a 3*VALUE_WIDTH + 2*FRACTION_BITS bit quotient. A singular
// matrix skips the divider and returns its elements.
// Reset (aresetn low, synchronous) empties the element count and drops any
// pending result. A stalled receiver holds the result register; the block
// waits before overwriting it and resumes when m_ready returns.
module matrix_inverse_4x4 #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_element_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_result_value,
    output logic [3:0]             m_result_index,
    output logic                   m_singular,
    output logic                   m_saturated,
    output logic                   m_last
);
    import mi4_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence the work; the datapath only executes commands.
    mi4_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Hold storage, arithmetic units and the output register.
    mi4_datapath #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_element_value (s_element_value),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_result_value  (m_result_value),
        .m_result_index  (m_result_index),
        .m_singular      (m_singular),
        .m_saturated     (m_saturated),
        .m_last          (m_last)
    );

endmodule
